// File: hw/rtl/windowed_min_jump_cost_macros.svh
// Assertion macros for the windowed minimum jump cost RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef WINDOWED_MIN_JUMP_COST_MACROS_SVH
`define WINDOWED_MIN_JUMP_COST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WMJC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define WMJC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/wmjc_pkg.sv
// Package for the windowed minimum jump cost block: widths, window sizing and shared types.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package wmjc_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int HEIGHT_W     = 16;
    localparam int COST_W       = 32;
    localparam int REACH_W      = 5;

    localparam logic [REACH_W-1:0] REACH_RESET = REACH_W'(2);
    localparam logic [COST_W-1:0]  COST_MAX    = {COST_W{1'b1}};

    localparam int IDX_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CMP_W       = (IDX_W + 1 > REACH_W) ? IDX_W + 1 : REACH_W;
    localparam int TREE_LEVELS = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 0;
    localparam int TREE_LEAVES = 1 << TREE_LEVELS;

    typedef struct packed {
        logic                       valid;
        logic signed [HEIGHT_W-1:0] height;
        logic [COST_W-1:0]          cost;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/wmjc_cell.sv
// One window cell: holds a past stone and its cost and offers the jump candidate to the new stone.
// Depends on wmjc_pkg.
`default_nettype none

module wmjc_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  wmjc_pkg::cell_ctrl_t                  ctrl,
    input  wmjc_pkg::entry_t                      prev,
    input  logic signed [wmjc_pkg::HEIGHT_W-1:0]  probe_height,
    input  logic                                  in_reach,
    output wmjc_pkg::entry_t                      entry,
    output logic [wmjc_pkg::COST_W-1:0]           cand
);
    import wmjc_pkg::*;

    logic                       valid_reg;
    logic                       valid_next;
    logic signed [HEIGHT_W-1:0] height_reg;
    logic [COST_W-1:0]          cost_reg;
    logic [HEIGHT_W:0]          diff;
    logic [HEIGHT_W:0]          mag;
    logic [COST_W:0]            sum;

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next = prev.valid;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            height_reg <= prev.height;
            cost_reg   <= prev.cost;
        end
    end

    always_comb
    begin
        diff = {probe_height[HEIGHT_W-1], probe_height} - {height_reg[HEIGHT_W-1], height_reg};
        mag  = diff[HEIGHT_W] ? (~diff + 1'b1) : diff;
        sum  = {1'b0, cost_reg} + {{(COST_W + 1 - HEIGHT_W){1'b0}}, mag[HEIGHT_W-1:0]};
        if (valid_reg && in_reach)
        begin
            cand = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
        end
        else
        begin
            cand = COST_MAX;
        end
    end

    assign entry.valid  = valid_reg;
    assign entry.height = height_reg;
    assign entry.cost   = cost_reg;

endmodule

`default_nettype wire

// File: hw/rtl/wmjc_min_tree.sv
// Minimum tree over the candidates offered by all window cells.
// Depends on wmjc_pkg; unused leaves are padded with the saturated cost.
`default_nettype none

module wmjc_min_tree (
    input  logic [wmjc_pkg::WINDOW_DEPTH-1:0][wmjc_pkg::COST_W-1:0] cand,
    output logic [wmjc_pkg::COST_W-1:0]                              min_cost
);
    import wmjc_pkg::*;

    logic [COST_W-1:0] node [1:2*TREE_LEAVES-1];

    for (genvar i = 0; i < TREE_LEAVES; i++)
    begin : g_leaf
        if (i < WINDOW_DEPTH)
        begin : g_used
            assign node[TREE_LEAVES + i] = cand[i];
        end
        else
        begin : g_pad
            assign node[TREE_LEAVES + i] = COST_MAX;
        end
    end

    for (genvar n = 1; n < TREE_LEAVES; n++)
    begin : g_node
        assign node[n] = (node[2*n+1] < node[2*n]) ? node[2*n+1] : node[2*n];
    end

    assign min_cost = node[1];

endmodule

`default_nettype wire

// File: hw/rtl/windowed_min_jump_cost.sv
// Top level of the windowed minimum jump cost block: cell chain, min tree and output skid buffer.
// Depends on wmjc_pkg, wmjc_cell, wmjc_min_tree and windowed_min_jump_cost_macros.svh.
// The block takes one stone per clock cycle while stone_stall is low and registers its cost
// for the result side; the cost of each stone is found in the same cycle as a minimum over all cells
// in parallel, so the cell adders and the min tree set the clock rate. A two-entry output
// buffer lets one more input transaction be taken while the result side stalls.
`default_nettype none

`include "windowed_min_jump_cost_macros.svh"

module windowed_min_jump_cost (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  reach_we,
    input  logic [wmjc_pkg::REACH_W-1:0]          reach_wdata,
    input  logic                                  stone_valid,
    output logic                                  stone_stall,
    input  logic signed [wmjc_pkg::HEIGHT_W-1:0]  height,
    input  logic                                  last,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic [wmjc_pkg::COST_W-1:0]           cost,
    output logic                                  is_last
);
    import wmjc_pkg::*;

    logic [REACH_W-1:0]                    reach_reg;
    logic                                  stone_fire;
    cell_ctrl_t                            ctrl;
    entry_t                                entry [WINDOW_DEPTH];
    entry_t                                head;
    logic [WINDOW_DEPTH-1:0]               in_reach;
    logic [WINDOW_DEPTH-1:0][COST_W-1:0]   cand;
    logic [COST_W-1:0]                     tree_min;
    logic [COST_W-1:0]                     cost_new;

    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic [COST_W-1:0]                     out_cost_reg;
    logic                                  out_last_reg;
    logic                                  skid_valid_reg;
    logic                                  skid_valid_next;
    logic [COST_W-1:0]                     skid_cost_reg;
    logic                                  skid_last_reg;
    logic                                  out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_reg <= REACH_RESET;
        end
        else if (reach_we)
        begin
            reach_reg <= reach_wdata;
        end
    end

    assign stone_stall = skid_valid_reg;
    assign stone_fire  = stone_valid && !skid_valid_reg;

    assign ctrl.shift = stone_fire && !last;
    assign ctrl.clear = stone_fire && last;

    assign cost_new     = entry[0].valid ? tree_min : '0;
    assign head.valid   = 1'b1;
    assign head.height  = height;
    assign head.cost    = cost_new;

    for (genvar j = 0; j < WINDOW_DEPTH; j++)
    begin : g_cell
        localparam logic [CMP_W-1:0] CELL_IDX = CMP_W'(j);

        assign in_reach[j] = (j == 0) || (CELL_IDX < CMP_W'(reach_reg));

        if (j == 0)
        begin : g_first
            wmjc_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .prev         (head),
                .probe_height (height),
                .in_reach     (in_reach[j]),
                .entry        (entry[j]),
                .cand         (cand[j])
            );
        end
        else
        begin : g_rest
            wmjc_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .prev         (entry[j-1]),
                .probe_height (height),
                .in_reach     (in_reach[j]),
                .entry        (entry[j]),
                .cand         (cand[j])
            );
        end
    end

    wmjc_min_tree u_min_tree (
        .cand     (cand),
        .min_cost (tree_min)
    );

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || stone_fire;
            skid_valid_next = 1'b0;
        end
        else if (stone_fire)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_cost_reg <= skid_cost_reg;
                out_last_reg <= skid_last_reg;
            end
            else if (stone_fire)
            begin
                out_cost_reg <= cost_new;
                out_last_reg <= last;
            end
        end
        else if (stone_fire)
        begin
            skid_cost_reg <= cost_new;
            skid_last_reg <= last;
        end
    end

    assign result_valid = out_valid_reg;
    assign cost         = out_cost_reg;
    assign is_last      = out_last_reg;

    `WMJC_ASSERT_IMPL(a_skid_implies_out, skid_valid_reg, out_valid_reg, "skid entry without output entry")
    `WMJC_ASSERT_IMPL(a_first_stone_zero, stone_fire && !entry[0].valid, cost_new == '0, "first stone cost not zero")
    `WMJC_ASSERT_NEXT(a_last_clears, stone_fire && last, !entry[0].valid, "window not cleared after last stone")
    `WMJC_ASSERT_NEXT(a_head_loaded, stone_fire && !last, entry[0].valid && entry[0].cost == $past(cost_new), "newest cell does not hold the new cost")
    `WMJC_ASSERT_NEXT(a_result_follows, stone_fire && out_free && !skid_valid_reg, out_valid_reg && cost == $past(cost_new), "result not presented after transaction")

endmodule

`default_nettype wire

// File: tb/sv/windowed_min_jump_cost_test.sv
// Self-checking testbench for windowed_min_jump_cost: drives stone sequences, reach writes and
// random idling on both channels, and checks every cost against a scoreboard that predicts it.
// Depends on wmjc_pkg and the windowed_min_jump_cost RTL.
`default_nettype none

module windowed_min_jump_cost_test;

    import wmjc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_STONES  = 730;
    localparam int CALM_STONES    = 150;
    localparam int CLIMB_STONES   = 40;

    typedef struct {
        logic [COST_W-1:0] cost;
        logic              is_last;
    } stone_result_t;

    class jump_cost_scoreboard;
        logic signed [HEIGHT_W-1:0] win_height[WINDOW_DEPTH];
        logic [COST_W-1:0]          win_cost[WINDOW_DEPTH];
        int unsigned                filled;
        logic [REACH_W-1:0]         reach;
        stone_result_t              expected_q[$];
        int                         errors;

        function new();
            clear_window();
            reach  = REACH_RESET;
            errors = 0;
        endfunction

        function void clear_window();
            for (int j = 0; j < WINDOW_DEPTH; j++) begin
                win_height[j] = '0;
                win_cost[j]   = '0;
            end
            filled = 0;
        endfunction

        function void set_reach(logic [REACH_W-1:0] value);
            reach = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_stone(logic signed [HEIGHT_W-1:0] h, logic l);
            int unsigned   eff;
            int unsigned   span;
            int            diff;
            logic [COST_W:0] total;
            logic [COST_W-1:0] best;
            stone_result_t item;
            eff = reach;
            if (eff < 1)
                eff = 1;
            if (eff > WINDOW_DEPTH)
                eff = WINDOW_DEPTH;
            if (filled == 0) begin
                best = '0;
            end
            else begin
                span = (filled < eff) ? filled : eff;
                best = COST_MAX;
                for (int j = 0; j < span; j++) begin
                    diff  = int'(h) - int'(win_height[j]);
                    if (diff < 0)
                        diff = -diff;
                    total = {1'b0, win_cost[j]} + (COST_W + 1)'(diff);
                    if (total[COST_W])
                        total[COST_W-1:0] = COST_MAX;
                    if (total[COST_W-1:0] < best)
                        best = total[COST_W-1:0];
                end
            end
            if (l) begin
                clear_window();
            end
            else begin
                for (int j = WINDOW_DEPTH - 1; j > 0; j--) begin
                    win_height[j] = win_height[j-1];
                    win_cost[j]   = win_cost[j-1];
                end
                win_height[0] = h;
                win_cost[0]   = best;
                if (filled < WINDOW_DEPTH)
                    filled++;
            end
            item.cost    = best;
            item.is_last = l;
            expected_q.push_back(item);
        endfunction

        function void check_result(logic [COST_W-1:0] c, logic l);
            stone_result_t item;
            if (expected_q.size() == 0) begin
                $error("unexpected result: cost %0d, is_last %0b", c, l);
                errors++;
                return;
            end
            item = expected_q.pop_front();
            if (c !== item.cost) begin
                $error("cost: expected %0d, actual %0d", item.cost, c);
                errors++;
            end
            if (l !== item.is_last) begin
                $error("is_last: expected %0b, actual %0b", item.is_last, l);
                errors++;
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       reach_we = 1'b0;
    logic [REACH_W-1:0]         reach_wdata = '0;
    logic                       stone_valid = 1'b0;
    logic                       stone_stall;
    logic signed [HEIGHT_W-1:0] height = '0;
    logic                       last = 1'b0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic [COST_W-1:0]          cost;
    logic                       is_last;

    bit                  idling_on = 1'b1;
    int                  stall_left = 0;
    int                  quiet_cycles = 0;
    jump_cost_scoreboard sb = new();

    windowed_min_jump_cost i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .reach_we     (reach_we),
        .reach_wdata  (reach_wdata),
        .stone_valid  (stone_valid),
        .stone_stall  (stone_stall),
        .height       (height),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cost         (cost),
        .is_last      (is_last)
    );

    always #5 clk = ~clk;

    task automatic send_stone(input logic signed [HEIGHT_W-1:0] h, input logic l);
        int gap;
        bit taken;
        gap = 0;
        if (idling_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            stone_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        stone_valid <= 1'b1;
        height      <= h;
        last        <= l;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !stone_stall;
        end
        sb.note_stone(h, l);
    endtask

    task automatic drain_stones();
        @(negedge clk);
        stone_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reach(input logic [REACH_W-1:0] value);
        drain_stones();
        @(negedge clk);
        reach_we    <= 1'b1;
        reach_wdata <= value;
        @(negedge clk);
        reach_we <= 1'b0;
        sb.set_reach(value);
    endtask

    function automatic logic signed [HEIGHT_W-1:0] pick_height();
        logic signed [HEIGHT_W-1:0] h;
        case ($urandom_range(0, 3))
            0: h = HEIGHT_W'($urandom_range(0, 65535));
            1: h = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: h = HEIGHT_W'($urandom_range(0, 200)) - 16'sd100;
        endcase
        return h;
    endfunction

    always @(negedge clk)
    begin
        if (!idling_on || !rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= $urandom_range(0, 8);
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(cost, is_last);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (stone_valid && !stone_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("windowed_min_jump_cost_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int len;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // A lone stone, then the height extremes at the reset reach.
        send_stone(16'sd5, 1'b1);
        send_stone(16'sh8000, 1'b0);
        send_stone(16'sh7fff, 1'b0);
        send_stone(16'sh8000, 1'b0);
        send_stone(16'sd0, 1'b0);
        send_stone(-16'sd1, 1'b0);
        send_stone(16'sd1, 1'b1);

        write_reach(5'd0);
        send_stone(16'sd10, 1'b0);
        send_stone(16'sd100, 1'b0);
        send_stone(-16'sd50, 1'b1);

        write_reach(5'd31);
        send_stone(16'sh7fff, 1'b0);
        send_stone(16'sd3, 1'b0);
        send_stone(16'sh8000, 1'b0);
        send_stone(16'sd7, 1'b1);

        // The reach shrinks in the middle of a sequence.
        write_reach(5'd16);
        send_stone(16'sd0, 1'b0);
        send_stone(16'sd400, 1'b0);
        send_stone(-16'sd300, 1'b0);
        send_stone(16'sd20, 1'b0);
        write_reach(5'd1);
        send_stone(16'sd25, 1'b0);
        send_stone(16'sd0, 1'b0);
        send_stone(16'sd1000, 1'b1);

        // Alternating extremes with a reach of one give the largest cost step on every stone after the first.
        for (int k = 0; k < CLIMB_STONES; k++)
            send_stone((k % 2 == 0) ? 16'sh8000 : 16'sh7fff, 1'b0);
        send_stone(16'sh8000, 1'b1);

        sent = 0;
        while (sent < RANDOM_STONES)
        begin
            if (idling_on && $urandom_range(0, 2) == 0)
                write_reach($urandom_range(0, 3) == 0 ? REACH_W'($urandom_range(0, 31))
                                                      : REACH_W'($urandom_range(1, 16)));
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 24);
            for (int k = 0; k < len; k++)
            begin
                if (sent >= RANDOM_STONES - CALM_STONES)
                    idling_on = 1'b0;
                if (idling_on && k == len / 2 && len > 4 && $urandom_range(0, 5) == 0)
                    write_reach(REACH_W'($urandom_range(0, 31)));
                send_stone(pick_height(), k == len - 1);
                sent++;
            end
        end

        drain_stones();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("windowed_min_jump_cost_test: done, clean");
        else
            $display("windowed_min_jump_cost_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/wmjc_pkg.sv
hw/rtl/wmjc_cell.sv
hw/rtl/wmjc_min_tree.sv
hw/rtl/windowed_min_jump_cost.sv
tb/sv/windowed_min_jump_cost_test.sv
